FILE: rtl/core/imu_ss_pkg.sv
// imu_ss_pkg: shared constants for the imu sample scheduler
`timescale 1ns / 1ps

package imu_ss_pkg;

   // tick counter value that schedules a magnetometer sample (the wrap to zero does too)
   localparam logic [7:0] MAG_TICK = 8'd128;

   // sensor source codes
   typedef enum logic {
      SRC_ACCEL = 1'b0,
      SRC_MAG   = 1'b1
   } sensor_src_type;

endpackage

FILE: rtl/core/imu_sample_scheduler_pingpong.sv
// imu_sample_scheduler_pingpong: tick driven sensor scheduler with ping-pong buffers
`timescale 1ns / 1ps

//  channel   direction  ports                               handshake
//  req       in         req_now_time                        req_valid / req_stall
//  rsp       out        rsp_sensor_source .. rsp_ready_flags rsp_valid / rsp_stall
//
//  one tick word per cycle while req_stall is low: scheduling state and the result register load at the accepting edge
//  a sample result appears on rsp in the cycle after its tick word is accepted
//  idle ticks (even counts other than 0 and 128) advance the counter and give no word
//  reset (synchronous, active high) clears counter, buffer state, ready flags and rsp_valid
//  req_stall is raised only while a held result is stalled by the sink

module imu_sample_scheduler_pingpong #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // tick words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_now_time,
   // sample schedule words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_sensor_source,
   output logic        rsp_target_buffer,
   output logic [7:0]  rsp_target_slot,
   output logic [15:0] rsp_sample_number,
   output logic [15:0] rsp_sample_time,
   output logic        rsp_handoff,
   output logic        rsp_handed_buffer,
   output logic [15:0] rsp_handed_first_mark,
   output logic [1:0]  rsp_ready_flags
);

   // buffer is full once the fill offset reaches this value
   localparam logic [7:0] DEPTH_LIMIT = 8'(BUFFER_DEPTH);

   // scheduling state: the shared tick counter and one entry per source
   logic [7:0]  tick_ff, tick_in;
   logic        active_ff [2];
   logic [7:0]  fill_ff   [2];
   logic [15:0] count_ff  [2];
   logic [1:0]  ready_ff  [2];

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        source_ff, buffer_ff, handoff_ff, handed_ff;
   logic [7:0]  slot_ff;
   logic [15:0] number_ff, time_ff, mark_ff;
   logic [1:0]  flags_ff;

   logic        req_take;
   logic        do_sample;
   logic        src;
   logic        act;
   logic        swap;
   logic        new_act;
   logic [7:0]  slot;
   logic [15:0] cnt_next;
   logic [1:0]  ready_new;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      tick_in   = tick_ff + 8'd1;
      // magnetometer on 0 and 128, accelerometer on any other odd count
      src       = (tick_in == imu_ss_pkg::MAG_TICK) || (tick_in == 8'd0);
      do_sample = src | tick_in[0];
      act       = active_ff[src];
      swap      = fill_ff[src] >= DEPTH_LIMIT;
      new_act   = swap ? ~act : act;
      slot      = swap ? 8'd0 : fill_ff[src];
      cnt_next  = count_ff[src] + 16'd1;
      ready_new = ready_ff[src];
      if (swap) begin
         // hand off the full buffer, invalidate the one we now fill
         ready_new[act]  = 1'b1;
         ready_new[~act] = 1'b0;
      end
   end

   // result valid: load on a sampling tick, drop once the sink takes the word
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_take && do_sample) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < 2; s++) begin
            active_ff[s] <= 1'b0;
            fill_ff[s]   <= '0;
            count_ff[s]  <= '0;
            ready_ff[s]  <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            tick_ff <= tick_in;
            if (do_sample) begin
               active_ff[src] <= new_act;
               fill_ff[src]   <= slot + 8'd1;
               count_ff[src]  <= cnt_next;
               ready_ff[src]  <= ready_new;
            end
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take && do_sample) begin
         source_ff  <= src;
         buffer_ff  <= new_act;
         slot_ff    <= slot;
         number_ff  <= cnt_next;
         time_ff    <= req_now_time;
         handoff_ff <= swap;
         handed_ff  <= swap ? act : 1'b0;
         mark_ff    <= swap ? count_ff[src] : 16'd0;
         flags_ff   <= ready_new;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_sensor_source     = source_ff;
   assign rsp_target_buffer     = buffer_ff;
   assign rsp_target_slot       = slot_ff;
   assign rsp_sample_number     = number_ff;
   assign rsp_sample_time       = time_ff;
   assign rsp_handoff           = handoff_ff;
   assign rsp_handed_buffer     = handed_ff;
   assign rsp_handed_first_mark = mark_ff;
   assign rsp_ready_flags       = flags_ff;

   // a source never has both buffers marked ready
   a_ready_exclusive: assert property (@(posedge clock) disable iff (reset)
      (ready_ff[0] != 2'b11) && (ready_ff[1] != 2'b11))
      else $error("both buffers of one source marked ready");

   // fill offsets never run past the buffer depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff[0] <= DEPTH_LIMIT) && (fill_ff[1] <= DEPTH_LIMIT))
      else $error("fill offset beyond buffer depth");

   // a handoff always restarts the new buffer at slot zero in the other buffer
   a_handoff_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && handoff_ff) |-> (slot_ff == 8'd0) && (buffer_ff != handed_ff))
      else $error("handoff word with bad slot or buffer");

   // an idle tick produces no new word
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (req_take && !do_sample && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("word produced on idle tick");

   // the handed buffer is flagged ready in the word that reports it
   a_handoff_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && handoff_ff) |-> flags_ff[handed_ff])
      else $error("handed buffer not flagged ready");

endmodule

FILE: dv/imu_sample_scheduler_pingpong_tb.sv
// testbench for the imu sample scheduler: tracks tick words and checks every sample word
`timescale 1ns / 1ps

module imu_sample_scheduler_pingpong_tb;

   localparam int DEPTH       = 32;
   localparam int ITEM_COUNT  = 1500;   // tick words offered over the whole run
   localparam int QUIET_LIMIT = 2000;   // cycles with no word moving before the run is called dead
   localparam int HOLD_CYCLES = 60;     // long sink hold-off, fills the block and stalls req
   localparam int REPORT_CAP  = 100;    // keeps a broken block from flooding the log
   localparam int DRAIN_WAIT  = 20;

   // timestamp corners: zero, all ones, single bits, single zeros, masks, alternating and mixed patterns
   localparam logic [15:0] CORNER [24] = '{
      16'h0000, 16'hffff, 16'h0001, 16'hfffe, 16'h8000, 16'h7fff,
      16'haaaa, 16'h5555, 16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0,
      16'h0002, 16'h0004, 16'h0008, 16'h0010, 16'h0020, 16'h0040,
      16'h0080, 16'h0100, 16'h0400, 16'h1000, 16'h4000, 16'hc3a5
   };

   // one sample schedule word as seen on rsp
   typedef struct {
      logic        source;
      logic        buffer_idx;
      logic [7:0]  slot;
      logic [15:0] number;
      logic [15:0] stamp;
      logic        handoff;
      logic        handed;
      logic [15:0] mark;
      logic [1:0]  flags;
   } schedule_word_type;

   // keeps a private copy of the scheduling state and the words still owed by the block
   class schedule_tracker_type;
      schedule_word_type pending_words [$];
      int unsigned  fails;
      int unsigned  ticks_taken;
      logic [7:0]   tick;
      logic         active_buf   [2];
      logic [7:0]   fill_level   [2];
      logic [15:0]  sample_total [2];
      logic [15:0]  last_stamp   [2];
      logic [15:0]  first_mark   [4];
      logic         ready        [4];

      function new();
         fails       = 0;
         ticks_taken = 0;
         tick        = '0;
         foreach (active_buf[i]) begin
            active_buf[i]   = 1'b0;
            fill_level[i]   = '0;
            sample_total[i] = '0;
            last_stamp[i]   = '0;
         end
         foreach (ready[i]) begin
            ready[i]      = 1'b0;
            first_mark[i] = '0;
         end
      endfunction

      // one accepted tick word: advance the counter, schedule a sample if due
      function void note_tick(logic [15:0] now);
         schedule_word_type          w;
         imu_ss_pkg::sensor_src_type src;
         logic                       act;
         int                         base;
         ticks_taken++;
         tick = tick + 8'd1;
         if (tick == imu_ss_pkg::MAG_TICK || tick == 8'd0) src = imu_ss_pkg::SRC_MAG;
         else if (tick[0]) src = imu_ss_pkg::SRC_ACCEL;
         else return;
         base      = 2 * int'(src);
         act       = active_buf[src];
         w.handoff = 1'b0;
         w.handed  = 1'b0;
         w.mark    = '0;
         // full buffer goes out before the new sample lands
         if (fill_level[src] >= DEPTH) begin
            w.handoff = 1'b1;
            w.handed  = act;
            w.mark    = sample_total[src];
            first_mark[base + act] = sample_total[src];
            ready[base + act]      = 1'b1;
            act                    = ~act;
            ready[base + act]      = 1'b0;
            active_buf[src]        = act;
            fill_level[src]        = '0;
         end
         w.slot            = fill_level[src];
         fill_level[src]   = fill_level[src] + 8'd1;
         sample_total[src] = sample_total[src] + 16'd1;
         last_stamp[src]   = now;
         w.source     = src;
         w.buffer_idx = act;
         w.number     = sample_total[src];
         w.stamp      = now;
         w.flags      = {ready[base + 1], ready[base]};
         pending_words.push_back(w);
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            fails++;
            if (fails <= REPORT_CAP) $error("%s: expected %0d, got %0d", field, want, got);
         end
      endfunction

      // one accepted rsp word against the oldest owed word
      function void check_word(schedule_word_type got);
         schedule_word_type want;
         if (pending_words.size() == 0) begin
            fails++;
            if (fails <= REPORT_CAP)
               $error("rsp word with no tick owing it: source %0d slot %0d",
                      got.source, got.slot);
            return;
         end
         want = pending_words.pop_front();
         compare("sensor_source", want.source, got.source);
         compare("target_buffer", want.buffer_idx, got.buffer_idx);
         compare("target_slot", want.slot, got.slot);
         compare("sample_number", want.number, got.number);
         compare("sample_time", want.stamp, got.stamp);
         compare("handoff", want.handoff, got.handoff);
         compare("handed_buffer", want.handed, got.handed);
         compare("handed_first_mark", want.mark, got.mark);
         compare("ready_flags", want.flags, got.flags);
      endfunction
   endclass

   // clock, reset and block ports; every input known from time zero
   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [15:0] req_now_time = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic        rsp_sensor_source;
   logic        rsp_target_buffer;
   logic [7:0]  rsp_target_slot;
   logic [15:0] rsp_sample_number;
   logic [15:0] rsp_sample_time;
   logic        rsp_handoff;
   logic        rsp_handed_buffer;
   logic [15:0] rsp_handed_first_mark;
   logic [1:0]  rsp_ready_flags;

   // idling rates in percent, changed by the stimulus between phases
   int send_gap_pct   = 13;
   int sink_stall_pct = 55;

   // long hold-off request from the stimulus, carried out by the sink process
   bit hold_go   = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   schedule_tracker_type book = new();

   always #1 clock = ~clock;

   imu_sample_scheduler_pingpong #(
      .BUFFER_DEPTH(DEPTH)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_now_time          (req_now_time),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_sensor_source     (rsp_sensor_source),
      .rsp_target_buffer     (rsp_target_buffer),
      .rsp_target_slot       (rsp_target_slot),
      .rsp_sample_number     (rsp_sample_number),
      .rsp_sample_time       (rsp_sample_time),
      .rsp_handoff           (rsp_handoff),
      .rsp_handed_buffer     (rsp_handed_buffer),
      .rsp_handed_first_mark (rsp_handed_first_mark),
      .rsp_ready_flags       (rsp_ready_flags)
   );

   // offer one tick word from a falling edge and hold it until the block takes it
   task automatic send_tick(input logic [15:0] stamp);
      // random gaps before the word, each one a full cycle with valid low
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_now_time <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // sink: random stall, or the one long hold-off once the stimulus asks for it
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < sink_stall_pct);
      end
   end

   // both channels sampled at the rising edge, before the block updates
   always @(posedge clock) begin
      schedule_word_type got;
      if (!reset) begin
         if (req_valid && !req_stall) book.note_tick(req_now_time);
         if (rsp_valid && !rsp_stall) begin
            got.source     = rsp_sensor_source;
            got.buffer_idx = rsp_target_buffer;
            got.slot       = rsp_target_slot;
            got.number     = rsp_sample_number;
            got.stamp      = rsp_sample_time;
            got.handoff    = rsp_handoff;
            got.handed     = rsp_handed_buffer;
            got.mark       = rsp_handed_first_mark;
            got.flags      = rsp_ready_flags;
            book.check_word(got);
         end
      end
   end

   // watchdog: too long without any word moving on either channel ends the run
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      logic [15:0] stamp;
      stamp = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: timestamp corners over the first ticks, mixing idle and accel ticks
      foreach (CORNER[i]) send_tick(CORNER[i]);

      // random: mostly steadily advancing time with some jumps anywhere in the range
      while (book.ticks_taken < ITEM_COUNT) begin
         if (book.ticks_taken >= 1000 && send_gap_pct == 55) begin
            // no idling from here on, and one long sink hold-off to back up req
            send_gap_pct   = 0;
            sink_stall_pct = 0;
            hold_go        = 1'b1;
         end else if (book.ticks_taken >= 500 && send_gap_pct == 13) begin
            send_gap_pct   = 55;
            sink_stall_pct = 13;
         end
         if ($urandom_range(7) == 0) stamp = 16'($urandom);
         else stamp = stamp + 16'($urandom_range(400, 1));
         send_tick(stamp);
      end
      req_valid <= 1'b0;

      // drain, then a quiet stretch so stray words still get caught
      while (book.pending_words.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (book.fails == 0 && book.pending_words.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/imu_ss_pkg.sv
rtl/core/imu_sample_scheduler_pingpong.sv
dv/imu_sample_scheduler_pingpong_tb.sv
